>>> rtl/fspp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspp_pkg
// Shared types and constants of the subtitle frame prefix parser.
// ----------------------------------------------------------------------------
package fspp_pkg;

  // Largest number of decimal digits in one frame number.
  localparam int unsigned MaxDigits = 10;

  localparam int unsigned CharW  = 8;
  localparam int unsigned FrameW = 35;
  localparam int unsigned PosW   = 5;

  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // The magnitude register holds any number of MaxDigits digits.
  localparam int unsigned AccW = $clog2(pow10(MaxDigits));
  localparam int unsigned CntW = $clog2(MaxDigits + 1);
  localparam int unsigned ExtW = (AccW > FrameW) ? AccW : FrameW;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  localparam logic [CharW-1:0] ChOpen  = 8'h7B;  // '{'
  localparam logic [CharW-1:0] ChClose = 8'h7D;  // '}'
  localparam logic [CharW-1:0] ChMinus = 8'h2D;  // '-'
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'

  typedef enum logic [7:0] {
    PhOpen1 = 8'b0000_0001,
    PhSign1 = 8'b0000_0010,
    PhDig1  = 8'b0000_0100,
    PhOpen2 = 8'b0000_1000,
    PhSign2 = 8'b0001_0000,
    PhDig2  = 8'b0010_0000,
    PhDone  = 8'b0100_0000,
    PhFail  = 8'b1000_0000
  } phase_e;

endpackage

>>> rtl/frame_subtitle_prefix_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_subtitle_prefix_parser_core
// Parses the two braced frame numbers at the head of a subtitle line.
// ----------------------------------------------------------------------------
// The block accepts one character transaction per clock cycle while its
// input does not stall, with no gaps needed between lines. Each transaction
// passes an input register and then updates the parse state, where the
// compare and the multiply-by-ten accumulate of the digit path form the loop
// that sets the rate. The result of a line goes into an output register
// when its last character leaves the input register. Input stall rises
// only when a line end waits behind an unaccepted result.
module frame_subtitle_prefix_parser_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [fspp_pkg::CharW-1:0]            character_i,
  input  logic                                  has_char_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  valid_res_o,
  output logic signed [fspp_pkg::FrameW-1:0]    start_frame_o,
  output logic signed [fspp_pkg::FrameW-1:0]    end_frame_o,
  output logic [fspp_pkg::PosW-1:0]             text_offset_o
);

  // Input register stage.
  logic                       s1_valid_q;
  logic [fspp_pkg::CharW-1:0] s1_char_q;
  logic                       s1_has_q;
  logic                       s1_last_q;
  logic                       s1_go;
  logic                       in_take;

  // Parse state.
  fspp_pkg::phase_e           phase_q, phase_d;
  logic                       minus_q, minus_d;
  logic [fspp_pkg::AccW-1:0]  acc_q, acc_d;
  logic [fspp_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [fspp_pkg::FrameW-1:0] first_q, first_d;
  logic [fspp_pkg::FrameW-1:0] second_q, second_d;
  logic [fspp_pkg::PosW-1:0]  pos_q, pos_d;

  // Result register.
  logic                        out_valid_q;
  logic                        res_ok_q;
  logic [fspp_pkg::FrameW-1:0] res_start_q;
  logic [fspp_pkg::FrameW-1:0] res_end_q;
  logic [fspp_pkg::PosW-1:0]   res_pos_q;

  logic                        is_digit;
  logic                        digit_path;
  logic                        second_num;
  logic [fspp_pkg::AccW+3:0]   acc_next;
  logic [fspp_pkg::ExtW-1:0]   mag_ext;
  logic [fspp_pkg::ExtW-1:0]   signed_ext;
  logic [fspp_pkg::FrameW-1:0] fin_value;
  logic                        res_ok;
  logic [fspp_pkg::FrameW-1:0] res_start;
  logic [fspp_pkg::FrameW-1:0] res_end;
  logic [fspp_pkg::PosW-1:0]   res_pos;

  // Only a line end has to wait for room in the result register.
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || s1_go) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= character_i;
      s1_has_q  <= has_char_i;
      s1_last_q <= last_i;
    end
  end

  assign is_digit = (s1_char_q >= fspp_pkg::ChZero) && (s1_char_q <= fspp_pkg::ChNine);

  // Shift-and-add times ten; the low nibble of an ASCII digit is its value.
  assign acc_next = (fspp_pkg::AccW + 4)'({acc_q, 3'b000})
                  + (fspp_pkg::AccW + 4)'({acc_q, 1'b0})
                  + (fspp_pkg::AccW + 4)'(s1_char_q[3:0]);

  assign mag_ext    = fspp_pkg::ExtW'(acc_q);
  assign signed_ext = minus_q ? (~mag_ext + fspp_pkg::ExtW'(1)) : mag_ext;
  assign fin_value  = signed_ext[fspp_pkg::FrameW-1:0];

  always_comb begin
    phase_d    = phase_q;
    minus_d    = minus_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    second_d   = second_q;
    pos_d      = pos_q;
    digit_path = 1'b0;
    second_num = 1'b0;
    res_ok     = 1'b0;
    res_start  = '0;
    res_end    = '0;
    res_pos    = '0;

    if (s1_go && s1_has_q && phase_q != fspp_pkg::PhDone && phase_q != fspp_pkg::PhFail) begin
      if (pos_q != fspp_pkg::PosMax) begin
        pos_d = pos_q + fspp_pkg::PosW'(1);
      end
      case (phase_q)
        fspp_pkg::PhOpen1, fspp_pkg::PhOpen2: begin
          if (s1_char_q == fspp_pkg::ChOpen) begin
            minus_d = 1'b0;
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = (phase_q == fspp_pkg::PhOpen1) ? fspp_pkg::PhSign1 : fspp_pkg::PhSign2;
          end else begin
            phase_d = fspp_pkg::PhFail;
          end
        end
        fspp_pkg::PhSign1, fspp_pkg::PhSign2: begin
          phase_d = (phase_q == fspp_pkg::PhSign1) ? fspp_pkg::PhDig1 : fspp_pkg::PhDig2;
          if (s1_char_q == fspp_pkg::ChMinus) begin
            minus_d = 1'b1;
          end else begin
            digit_path = 1'b1;
            second_num = (phase_q == fspp_pkg::PhSign2);
          end
        end
        fspp_pkg::PhDig1, fspp_pkg::PhDig2: begin
          digit_path = 1'b1;
          second_num = (phase_q == fspp_pkg::PhDig2);
        end
        default: begin
          phase_d = fspp_pkg::PhFail;
        end
      endcase

      if (digit_path) begin
        if (is_digit) begin
          if (cnt_q >= fspp_pkg::CntW'(fspp_pkg::MaxDigits)) begin
            phase_d = fspp_pkg::PhFail;
          end else begin
            acc_d = acc_next[fspp_pkg::AccW-1:0];
            cnt_d = cnt_q + fspp_pkg::CntW'(1);
          end
        end else if (s1_char_q == fspp_pkg::ChClose && cnt_q != '0) begin
          if (second_num) begin
            second_d = fin_value;
            phase_d  = fspp_pkg::PhDone;
          end else begin
            first_d = fin_value;
            phase_d = fspp_pkg::PhOpen2;
          end
        end else begin
          phase_d = fspp_pkg::PhFail;
        end
      end
    end

    // A line end reports the state after its own character and starts over.
    if (s1_go && s1_last_q) begin
      res_ok   = (phase_d == fspp_pkg::PhDone);
      if (res_ok) begin
        res_start = first_d;
        res_end   = second_d;
        res_pos   = pos_d;
      end
      phase_d  = fspp_pkg::PhOpen1;
      minus_d  = 1'b0;
      acc_d    = '0;
      cnt_d    = '0;
      first_d  = '0;
      second_d = '0;
      pos_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fspp_pkg::PhOpen1;
      minus_q  <= 1'b0;
      acc_q    <= '0;
      cnt_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      pos_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      minus_q  <= minus_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      first_q  <= first_d;
      second_q <= second_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      res_ok_q    <= res_ok;
      res_start_q <= res_start;
      res_end_q   <= res_end;
      res_pos_q   <= res_pos;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = res_ok_q;
  assign start_frame_o = res_start_q;
  assign end_frame_o   = res_end_q;
  assign text_offset_o = res_pos_q;

endmodule

>>> rtl/fspp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspp_checker
// Port-level checks of the subtitle frame prefix parser.
// ----------------------------------------------------------------------------
module fspp_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_o,
  input  logic [fspp_pkg::CharW-1:0]            character_i,
  input  logic                                  has_char_i,
  input  logic                                  last_i,
  input  logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  input  logic                                  valid_res_o,
  input  logic signed [fspp_pkg::FrameW-1:0]    start_frame_o,
  input  logic signed [fspp_pkg::FrameW-1:0]    end_frame_o,
  input  logic [fspp_pkg::PosW-1:0]             text_offset_o
);

  // The input side only backs up behind a result that is not yet taken.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(valid_res_o)
      && $stable(start_frame_o) && $stable(end_frame_o) && $stable(text_offset_o)))
    else $error("stalled result changed");

  a_failed_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (start_frame_o == '0 && end_frame_o == '0 && text_offset_o == '0))
    else $error("failed line carries nonzero fields");

  // The shortest good prefix has six characters.
  a_min_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |-> (text_offset_o >= fspp_pkg::PosW'(6)))
    else $error("text offset too small for a good prefix");

  // Every line end shows up as a result when nothing stalls.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i && !out_valid_o) ##1 !out_stall_i
      |=> out_valid_o)
    else $error("line end produced no result");

endmodule

bind frame_subtitle_prefix_parser_core fspp_checker u_fspp_checker (.*);
